>>> rtl/tts_pkg.sv
// Shared types and constants for the TPM TIS-over-SPI target.
// No dependencies; used by tpm_tis_spi_target.

package tts_pkg;

    // Item operation codes, carried in the slave-side tuser
    localparam logic [2:0] OP_SPI_BYTE    = 3'd0;
    localparam logic [2:0] OP_STS_UPDATE  = 3'd1;
    localparam logic [2:0] OP_FIFO_LOAD   = 3'd2;
    localparam logic [2:0] OP_FIFO_PEEK   = 3'd3;
    localparam logic [2:0] OP_FIFO_REWIND = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ACCESS_ADDR = 3'd0;
    localparam logic [2:0] CFG_STATUS_ADDR = 3'd1;
    localparam logic [2:0] CFG_FIFO_ADDR   = 3'd2;
    localparam logic [2:0] CFG_VID_ADDR    = 3'd3;
    localparam logic [2:0] CFG_RID_ADDR    = 3'd4;

    // Register map defaults after reset
    localparam logic [23:0] RST_ACCESS_ADDR = 24'hD40000;
    localparam logic [23:0] RST_STATUS_ADDR = 24'hD40018;
    localparam logic [23:0] RST_FIFO_ADDR   = 24'hD40024;
    localparam logic [23:0] RST_VID_ADDR    = 24'hD40F00;
    localparam logic [23:0] RST_RID_ADDR    = 24'hD40F04;

    // Status byte 0 bits
    localparam logic [7:0] STS_VALID      = 8'h80;
    localparam logic [7:0] STS_CMD_READY  = 8'h40;
    localparam logic [7:0] STS_DATA_AVAIL = 8'h10;

    // Fixed read-back bytes
    localparam logic [7:0] ACCESS_BYTE = 8'hA0;
    localparam logic [7:0] RID_BYTE    = 8'h55;

    // Result of the front stage, waiting for the FIFO read data
    typedef struct packed {
        logic        loaded;    // a new MISO byte is loaded
        logic        from_ram;  // MISO byte comes from the FIFO read port
        logic [7:0]  miso;      // MISO byte when not from the read port
        logic [31:0] status;    // status word of this beat
        logic        peek_ram;  // peek data comes from the read port
        logic        done;      // data phase ended on this byte
    } t_pipe;

    // Vendor identifier bytes
    function automatic logic [7:0] vid_byte(input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0: b = 8'hC0;
            2'd1: b = 8'hFF;
            2'd2: b = 8'hEE;
            2'd3: b = 8'hAA;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/tts_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tpm_tis_spi_target.sv
// Top level of the TPM TIS-over-SPI target: frame parser, register map and FIFO store.
// Depends on tts_pkg and tts_ram.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser op, tdata operands
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata bytes, tuser loaded, tlast
//  cfg      | in        | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// One item is accepted per cycle unless m_axis stalls; it passes the second stage and the
// output register to m_axis. Parser state updates and the FIFO store access happen at the
// accept edge; the FIFO RAM's registered read data is merged in the second stage.
// Reset is synchronous, active low; the FIFO store is not cleared and needs no sweep.
// A stalled m_axis holds the output register, then the second stage, then s_axis_tready.

module tpm_tis_spi_target #(
    parameter int FIFO_DEPTH = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] spi_byte, [39:8] set_mask, [71:40] clear_mask, [82:72] fifo_index,
    // [90:83] fifo_data, [102:91] response_length, [103] zero
    input  logic [103:0] s_axis_tdata,
    // [2:0] op
    input  logic [2:0]   s_axis_tuser,
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] miso_byte, [39:8] status_word, [47:40] fifo_read_data
    output logic [47:0]  m_axis_tdata,
    // [0] miso_loaded
    output logic         m_axis_tuser,
    // frame_done
    output logic         m_axis_tlast,
    // configuration
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    localparam int AW   = $clog2(FIFO_DEPTH);
    localparam int DEPW = $clog2(FIFO_DEPTH + 1);
    localparam int POSW = (DEPW > 11) ? DEPW : 11;
    localparam int CMPW = (POSW > 12) ? POSW : 12;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(FIFO_DEPTH);

    // Input fields
    logic [2:0]  in_op;
    logic [7:0]  in_byte;
    logic [31:0] in_set;
    logic [31:0] in_clr;
    logic [10:0] in_fidx;
    logic [7:0]  in_fdata;
    logic [11:0] in_rlen;

    assign in_op    = s_axis_tuser;
    assign in_byte  = s_axis_tdata[7:0];
    assign in_set   = s_axis_tdata[39:8];
    assign in_clr   = s_axis_tdata[71:40];
    assign in_fidx  = s_axis_tdata[82:72];
    assign in_fdata = s_axis_tdata[90:83];
    assign in_rlen  = s_axis_tdata[102:91];

    // Configuration registers
    logic [23:0] r_access_addr, r_status_addr, r_fifo_addr, r_vid_addr, r_rid_addr;

    // Parser and register-map state
    logic [6:0]      r_bytes_left,    n_bytes_left;
    logic            r_read_frame,    n_read_frame;
    logic            r_dummy_pending, n_dummy_pending;
    logic [23:0]     r_frame_address, n_frame_address;
    logic [1:0]      r_address_count, n_address_count;
    logic [6:0]      r_data_index,    n_data_index;
    logic [3:0][7:0] r_status,        n_status;
    logic [31:0]     r_status_shadow, n_status_shadow;
    logic [POSW-1:0] r_fifo_position, n_fifo_position;
    logic [11:0]     r_fifo_limit,    n_fifo_limit;

    // Pipeline
    logic                r_p_valid;
    tts_pkg::t_pipe      r_p, n_p;
    logic [7:0]          r_miso_latch;
    logic                r_o_valid;
    logic [47:0]         r_o_data;
    logic                r_o_loaded;
    logic                r_o_done;

    // FIFO RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic s_accept, p_move;

    assign p_move        = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_p_valid || p_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    tts_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Parse the beat, update state and issue the FIFO access
    always_comb begin
        logic            serve;
        logic [6:0]      idx;
        logic [6:0]      left_dec;
        logic [CMPW-1:0] pos_ext;
        logic [CMPW-1:0] npos_ext;
        logic [CMPW-1:0] fidx_ext;

        n_bytes_left    = r_bytes_left;
        n_read_frame    = r_read_frame;
        n_dummy_pending = r_dummy_pending;
        n_frame_address = r_frame_address;
        n_address_count = r_address_count;
        n_data_index    = r_data_index;
        n_status        = r_status;
        n_status_shadow = r_status_shadow;
        n_fifo_position = r_fifo_position;
        n_fifo_limit    = r_fifo_limit;

        n_p          = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = '0;
        ram_raddr    = '0;
        ram_wdata    = in_byte;

        serve    = 1'b0;
        idx      = r_data_index;
        left_dec = r_bytes_left - 7'd1;
        pos_ext  = CMPW'(r_fifo_position);
        npos_ext = pos_ext;
        fidx_ext = CMPW'(in_fidx);

        unique case (in_op)
            tts_pkg::OP_SPI_BYTE: begin
                if (r_bytes_left == 7'd0) begin
                    // header, or the dummy byte after a read frame
                    if (r_dummy_pending && r_read_frame) begin
                        n_dummy_pending = 1'b0;
                    end else begin
                        n_bytes_left = {1'b0, in_byte[5:0]} + 7'd1;
                    end
                    n_data_index    = '0;
                    n_read_frame    = in_byte[7];
                    n_frame_address = '0;
                    n_address_count = '0;
                    n_p.loaded      = 1'b1;
                end else if (r_address_count != 2'd3) begin
                    // address bytes, most significant first
                    n_frame_address = {r_frame_address[15:0], in_byte};
                    n_address_count = r_address_count + 2'd1;
                    if (r_address_count != 2'd2) begin
                        n_p.loaded = 1'b1;
                    end else if (r_read_frame) begin
                        serve = 1'b1;
                    end
                end else begin
                    serve = 1'b1;
                end

                if (serve) begin
                    n_bytes_left = left_dec;
                    if (left_dec == 7'd0) begin
                        if (r_read_frame) begin
                            n_dummy_pending = 1'b1;
                        end
                        n_address_count = '0;
                        n_data_index    = '0;
                        n_p.done        = 1'b1;
                    end else begin
                        n_data_index = r_data_index + 7'd1;
                    end
                    n_p.loaded = 1'b1;

                    // data-phase target, first match wins
                    priority if (n_frame_address == r_access_addr) begin
                        n_p.miso = tts_pkg::ACCESS_BYTE;
                    end else if (n_frame_address == r_status_addr) begin
                        if (r_read_frame) begin
                            n_p.miso = (idx < 7'd4) ? r_status[idx[1:0]] : 8'h00;
                        end else begin
                            if (idx < 7'd4) begin
                                n_status[idx[1:0]] = in_byte;
                            end
                            n_status[0] = n_status[0] & ~tts_pkg::STS_VALID;
                        end
                    end else if (n_frame_address == r_fifo_addr) begin
                        if (pos_ext < DEPTH_C) begin
                            if (r_read_frame) begin
                                ram_re       = 1'b1;
                                ram_raddr    = pos_ext[AW-1:0];
                                n_p.from_ram = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_ext[AW-1:0];
                            end
                            n_fifo_position = r_fifo_position + POSW'(1);
                            npos_ext        = CMPW'(n_fifo_position);
                        end
                        if (r_fifo_limit != 12'd0 && npos_ext >= CMPW'(r_fifo_limit)) begin
                            n_status[0] = n_status[0] & ~tts_pkg::STS_DATA_AVAIL;
                        end
                    end else if (n_frame_address == r_vid_addr) begin
                        n_p.miso = (idx < 7'd4) ? tts_pkg::vid_byte(idx[1:0]) : 8'h00;
                    end else if (n_frame_address == r_rid_addr) begin
                        n_p.miso = tts_pkg::RID_BYTE;
                    end else begin
                        n_p.miso = 8'h00;
                    end
                end
            end
            tts_pkg::OP_STS_UPDATE: begin
                // merge through the sticky shadow
                n_status_shadow = ((r_status_shadow | r_status | in_set) & ~in_clr)
                                  | {24'h0, tts_pkg::STS_VALID};
                n_status        = n_status_shadow;
            end
            tts_pkg::OP_FIFO_LOAD: begin
                if (fidx_ext < DEPTH_C) begin
                    ram_we    = 1'b1;
                    ram_waddr = fidx_ext[AW-1:0];
                    ram_wdata = in_fdata;
                end
            end
            tts_pkg::OP_FIFO_PEEK: begin
                if (fidx_ext < DEPTH_C) begin
                    ram_re       = 1'b1;
                    ram_raddr    = fidx_ext[AW-1:0];
                    n_p.peek_ram = 1'b1;
                end
            end
            tts_pkg::OP_FIFO_REWIND: begin
                n_fifo_position = POSW'(in_fidx);
                n_fifo_limit    = in_rlen;
            end
            default: begin
            end
        endcase

        n_p.status = n_status;

        // no access unless the beat is taken
        if (!s_accept) begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_addr <= tts_pkg::RST_ACCESS_ADDR;
            r_status_addr <= tts_pkg::RST_STATUS_ADDR;
            r_fifo_addr   <= tts_pkg::RST_FIFO_ADDR;
            r_vid_addr    <= tts_pkg::RST_VID_ADDR;
            r_rid_addr    <= tts_pkg::RST_RID_ADDR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tts_pkg::CFG_ACCESS_ADDR: r_access_addr <= i_cfg_data;
                tts_pkg::CFG_STATUS_ADDR: r_status_addr <= i_cfg_data;
                tts_pkg::CFG_FIFO_ADDR:   r_fifo_addr   <= i_cfg_data;
                tts_pkg::CFG_VID_ADDR:    r_vid_addr    <= i_cfg_data;
                tts_pkg::CFG_RID_ADDR:    r_rid_addr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance parser state on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left    <= '0;
            r_read_frame    <= 1'b0;
            r_dummy_pending <= 1'b0;
            r_frame_address <= '0;
            r_address_count <= '0;
            r_data_index    <= '0;
            r_status        <= {24'h0, tts_pkg::STS_VALID | tts_pkg::STS_CMD_READY};
            r_status_shadow <= '0;
            r_fifo_position <= '0;
            r_fifo_limit    <= '0;
        end else if (s_accept) begin
            r_bytes_left    <= n_bytes_left;
            r_read_frame    <= n_read_frame;
            r_dummy_pending <= n_dummy_pending;
            r_frame_address <= n_frame_address;
            r_address_count <= n_address_count;
            r_data_index    <= n_data_index;
            r_status        <= n_status;
            r_status_shadow <= n_status_shadow;
            r_fifo_position <= n_fifo_position;
            r_fifo_limit    <= n_fifo_limit;
        end
    end

    // Second stage: hold the beat while the read data arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (s_accept) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_p <= n_p;
        end
    end

    // Merge read data; beats that load nothing repeat the latched MISO byte
    logic [7:0] p_miso;
    logic [7:0] p_peek;

    assign p_miso = r_p.loaded ? (r_p.from_ram ? ram_rdata : r_p.miso) : r_miso_latch;
    assign p_peek = r_p.peek_ram ? ram_rdata : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miso_latch <= '0;
        end else if (r_p_valid && p_move) begin
            r_miso_latch <= p_miso;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_p_valid && p_move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && p_move) begin
            r_o_data   <= {p_peek, r_p.status, p_miso};
            r_o_loaded <= r_p.loaded;
            r_o_done   <= r_p.done;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_loaded;
    assign m_axis_tlast  = r_o_done;

`ifndef SYNTHESIS
    a_ram_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("FIFO RAM read and write issued together");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_p_valid)
        else $error("accepted beat did not reach the second stage");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame end without a loaded MISO byte");

    a_idle_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == 7'd0) |-> (r_address_count == 2'd0))
        else $error("address count left over between frames");

    a_dummy_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dummy_pending |-> (r_read_frame && r_bytes_left == 7'd0))
        else $error("dummy byte pending outside a finished read frame");
`endif

endmodule
